FILE: sv/tksi_pkg.sv
// ----------------------------------------------------------------------------
// tksi_pkg
// Shared constants for the top-k sorted insertion table: field widths,
// action codes and parameter defaults.
// ----------------------------------------------------------------------------
package tksi_pkg;

    // parameter defaults
    localparam int TABLE_DEPTH_DEF = 10;
    localparam int TAG_BITS_DEF    = 64;

    // fixed transaction field widths
    localparam int TAG_W   = 64;
    localparam int SCORE_W = 32;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 4;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

endpackage

FILE: sv/tksi_item_if.sv
// ----------------------------------------------------------------------------
// tksi_item_if
// Input channel of the top-k table: insert or read request.
// ----------------------------------------------------------------------------
interface tksi_item_if;
    import tksi_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [TAG_W-1:0]          entry_tag;
    logic signed [SCORE_W-1:0] entry_score;
    logic [IDX_W-1:0]          read_index;

    modport source (
        output valid, action, entry_tag, entry_score, read_index,
        input  ready
    );

    modport sink (
        input  valid, action, entry_tag, entry_score, read_index,
        output ready
    );

endinterface

FILE: sv/tksi_result_if.sv
// ----------------------------------------------------------------------------
// tksi_result_if
// Output channel of the top-k table: one result per request.
// ----------------------------------------------------------------------------
interface tksi_result_if;
    import tksi_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      accepted;
    logic [IDX_W-1:0]          insert_rank;
    logic [CNT_W-1:0]          entry_count;
    logic [TAG_W-1:0]          read_tag;
    logic signed [SCORE_W-1:0] read_score;
    logic                      read_valid;

    modport source (
        output valid, accepted, insert_rank, entry_count, read_tag, read_score,
               read_valid,
        input  ready
    );

    modport sink (
        input  valid, accepted, insert_rank, entry_count, read_tag, read_score,
               read_valid,
        output ready
    );

endinterface

FILE: sv/top_k_sorted_insert.sv
// ----------------------------------------------------------------------------
// top_k_sorted_insert
// Keeps up to TABLE_DEPTH (tag, score) entries in descending score order,
// rank 0 highest. An insert transaction always enters while the table is not
// full; once full it is dropped if its score is below the last entry, and
// otherwise goes in ahead of any equal scores while the last entry falls out.
// A read transaction returns the entry at a rank, or zeros past the count.
// Every request gives exactly one result. The entries sit in one memory with
// one write and one registered read port, so the block handles one request
// at a time: a read gives its result from S_RDATA, the state after
// acceptance; an insert walks up from the bottom of the table, moving one
// entry down per cycle (a read and a write on that memory), after a check
// against the last entry in S_CHECK when the table is full, and gives its
// result when the walk stops or the new entry lands at rank 0. A new
// request is taken once the sequencer is idle, the cycle after the result
// is loaded, and the result register is free or being emptied in the same
// cycle, so no request is taken before the last one has given its result.
// Tags are kept to their low TAG_BITS bits.
// ----------------------------------------------------------------------------
module top_k_sorted_insert #(
    parameter int TABLE_DEPTH = tksi_pkg::TABLE_DEPTH_DEF,
    parameter int TAG_BITS    = tksi_pkg::TAG_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tksi_item_if.sink     i_item,
    tksi_result_if.source o_result
);
    import tksi_pkg::*;

    // widths
    localparam int AW = $clog2(TABLE_DEPTH);        // table address
    localparam int CW = $clog2(TABLE_DEPTH + 1);    // entry count
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;  // index vs count compare
    localparam int EW = TAG_BITS + SCORE_W;         // one stored entry

    // sequencer, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,  // full table: compare against last entry
        S_SCAN  = 5'b00100,  // walk up, moving entries down one rank
        S_HEAD  = 5'b01000,  // new entry lands at rank 0
        S_RDATA = 5'b10000   // read data back from memory
    } t_state;

    t_state r_state, n_state;

    // table memory: {tag, score} per rank
    logic [EW-1:0] r_mem [TABLE_DEPTH];
    logic [EW-1:0] r_rd;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    // request held for the duration of the transaction
    logic [CW-1:0]             r_count, n_count;
    logic [AW-1:0]             r_k, n_k;        // rank being filled by the walk
    logic [TAG_BITS-1:0]       r_tag, n_tag;
    logic signed [SCORE_W-1:0] r_score, n_score;
    logic                      r_hit, n_hit;

    // result register
    logic                      r_out_valid;
    logic                      r_acc;
    logic [IDX_W-1:0]          r_rank;
    logic [CNT_W-1:0]          r_ocount;
    logic [TAG_W-1:0]          r_otag;
    logic signed [SCORE_W-1:0] r_oscore;
    logic                      r_ovalid;

    // result load from the sequencer
    logic                      fin;
    logic                      fin_acc;
    logic [AW-1:0]             fin_rank;
    logic                      fin_read;

    logic                      in_take;
    logic                      full;
    logic signed [SCORE_W-1:0] rd_score;
    logic [TAG_BITS-1:0]       rd_tag;

    assign full     = (r_count == CW'(TABLE_DEPTH));
    assign rd_score = signed'(r_rd[SCORE_W-1:0]);
    assign rd_tag   = r_rd[EW-1:SCORE_W];

    assign i_item.ready = (r_state == S_IDLE) && (!r_out_valid || o_result.ready);
    assign in_take      = i_item.valid && i_item.ready;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_k       = r_k;
        n_tag     = r_tag;
        n_score   = r_score;
        n_hit     = r_hit;
        mem_we    = 1'b0;
        mem_waddr = r_k;
        mem_wdata = {r_tag, r_score};
        mem_re    = 1'b0;
        mem_raddr = r_k;
        fin       = 1'b0;
        fin_acc   = 1'b0;
        fin_rank  = '0;
        fin_read  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_tag   = TAG_BITS'(i_item.entry_tag);
                    n_score = i_item.entry_score;
                    if (i_item.action == ACT_READ) begin
                        n_hit     = XW'(i_item.read_index) < XW'(r_count);
                        mem_re    = n_hit;
                        mem_raddr = AW'(i_item.read_index);
                        n_state   = S_RDATA;
                    end else if (full) begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(TABLE_DEPTH - 1);
                        n_state   = S_CHECK;
                    end else if (r_count == '0) begin
                        n_state = S_HEAD;
                    end else begin
                        // start the walk at the first free rank
                        n_k       = AW'(r_count);
                        mem_re    = 1'b1;
                        mem_raddr = AW'(r_count - CW'(1));
                        n_state   = S_SCAN;
                    end
                end
            end

            S_CHECK: begin
                if (r_score < rd_score) begin
                    // below the last entry: dropped, table untouched
                    fin     = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    // last entry is overwritten by the walk
                    n_k       = AW'(TABLE_DEPTH - 1);
                    mem_re    = 1'b1;
                    mem_raddr = AW'(TABLE_DEPTH - 2);
                    n_state   = S_SCAN;
                end
            end

            S_SCAN: begin
                // r_rd holds rank r_k-1; the read of r_k-2 never meets the write
                mem_we    = 1'b1;
                mem_waddr = r_k;
                if (rd_score > r_score) begin
                    fin      = 1'b1;
                    fin_acc  = 1'b1;
                    fin_rank = r_k;
                    n_state  = S_IDLE;
                end else begin
                    // equal or lower scores move down: new entry goes ahead of ties
                    mem_wdata = r_rd;
                    if (r_k == AW'(1)) begin
                        n_state = S_HEAD;
                    end else begin
                        n_k       = r_k - AW'(1);
                        mem_re    = 1'b1;
                        mem_raddr = AW'(32'(r_k) - 32'd2);
                    end
                end
            end

            S_HEAD: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                fin       = 1'b1;
                fin_acc   = 1'b1;
                n_state   = S_IDLE;
            end

            S_RDATA: begin
                fin      = 1'b1;
                fin_read = 1'b1;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin_acc && !full) begin
            n_count = r_count + CW'(1);
        end
    end

    // memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_tag   <= n_tag;
        r_score <= n_score;
        r_hit   <= n_hit;
        if (fin) begin
            r_acc    <= fin_acc;
            r_rank   <= fin_acc ? IDX_W'(fin_rank) : '0;
            r_ocount <= CNT_W'(n_count);
            r_ovalid <= fin_read && r_hit;
            r_otag   <= (fin_read && r_hit) ? TAG_W'(rd_tag) : '0;
            r_oscore <= (fin_read && r_hit) ? rd_score : '0;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.accepted    = r_acc;
    assign o_result.insert_rank = r_rank;
    assign o_result.entry_count = r_ocount;
    assign o_result.read_tag    = r_otag;
    assign o_result.read_score  = r_oscore;
    assign o_result.read_valid  = r_ovalid;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write hit the same rank in one cycle");

    a_scan_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k != '0) && (CW'(r_k) <= r_count))
        else $error("walk rank out of range");

    a_result_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |-> !r_out_valid)
        else $error("result produced while previous result pending");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count))
            |-> (r_count == $past(r_count) + CW'(1)))
        else $error("entry count moved by other than one");

endmodule
